// File: src/efce_pkg.sv
package efce_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic OP_RX    = 1'b0;
  localparam logic OP_READY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

// File: src/echo_fifo_crlf_expand_core.sv
// Channel | Handshake          | Payload
// --------+--------------------+---------------------------------------------------
// in      | in_valid, in_stall | opcode, rx_byte
// out     | out_valid,out_stall| tx_valid, tx_byte, dropped, send_enabled, fill_level
//
// A received byte is written to the ring at the transfer edge and its result
// is registered on the same edge. A ready event that sends reads the ring into a
// read register first; the result is then registered from that read data.
// Reset clears head, count and out_valid, returns to idle and sets sending on;
// the ring and output payload are not cleared. in_stall is high while a read
// is pending or while a result waits in the output register and out_stall is high.
module echo_fifo_crlf_expand_core #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       dropped,
  output logic       send_enabled,
  output logic [6:0] fill_level
);

  import efce_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_EXT  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

  logic [7:0] ring [DEPTH];
  logic [7:0] rd_data;

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          send_on, send_on_next;

  logic          in_acc;
  logic          full;
  logic          empty;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;

  logic          load;
  logic          res_tx_valid;
  logic [7:0]    res_tx_byte;
  logic          res_dropped;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);

  assign tail_sum = {1'b0, head} + (AW+1)'(count);
  assign tail     = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : tail_sum[AW-1:0];
  assign head_inc = (head == LAST_INDEX) ? '0 : head + AW'(1);

  always_comb begin
    state_next   = state;
    head_next    = head;
    count_next   = count;
    send_on_next = send_on;
    wr_en        = 1'b0;
    wr_addr      = tail;
    wr_data      = rx_byte;
    rd_en        = 1'b0;
    load         = 1'b0;
    res_tx_valid = 1'b0;
    res_tx_byte  = '0;
    res_dropped  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode == OP_RX) begin
            load = 1'b1;
            if (full) begin
              res_dropped = 1'b1;
            end else begin
              wr_en        = 1'b1;
              count_next   = count + CW'(1);
              send_on_next = 1'b1;
            end
          end else if (send_on && !empty) begin
            rd_en      = 1'b1;
            state_next = S_READ;
          end else begin
            load         = 1'b1;
            send_on_next = 1'b0;
          end
        end
      end
      S_READ: begin
        load         = 1'b1;
        res_tx_valid = 1'b1;
        res_tx_byte  = rd_data;
        state_next   = S_IDLE;
        if (rd_data == CHAR_CR) begin
          wr_en   = 1'b1;
          wr_addr = head;
          wr_data = CHAR_LF;
        end else begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= ring[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      send_on <= 1'b1;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      send_on <= send_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_valid     <= res_tx_valid;
      tx_byte      <= res_tx_byte;
      dropped      <= res_dropped;
      send_enabled <= send_on_next;
      fill_level   <= 7'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("ring count exceeds depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("read completes while output register is occupied");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("non-zero byte on a result that sends nothing");

  a_drop_no_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !tx_valid && fill_level == 7'(FULL_COUNT))
    else $error("dropped result inconsistent with full ring");
`endif

endmodule
